>>> hdl/tfn_pkg.sv
// Package with widths, payload layout and a helper function for the triangle face normal block.
`timescale 1ns / 1ps
package tfn_pkg;

  localparam int CoordW  = 12;
  localparam int NormFrac = 14;
  localparam int OutW    = 16;
  localparam int EdgeW   = CoordW + 1;
  localparam int ProdW   = 2 * EdgeW;
  localparam int CrossW  = ProdW + 1;
  localparam int MagW    = ProdW;
  localparam int LzW     = $clog2(MagW);
  localparam int NrmW    = 31;
  localparam int SqW     = 2 * NrmW;
  localparam int SumW    = SqW + 2;
  localparam int RootW   = SumW / 2;
  localparam int RemW    = RootW + 2;
  localparam int QuoW    = NormFrac + 2;
  localparam int NumW    = NrmW + NormFrac + 1;
  localparam int DrW     = RootW + 1;
  localparam int InDataW = ((9 * CoordW + 7) / 8) * 8;
  localparam int OutDataW = ((3 * OutW + 7) / 8) * 8;

  function automatic logic [LzW-1:0] lead_zeros(input logic [MagW-1:0] v);
    logic [LzW-1:0] r;
    r = '0;
    for (int i = 0; i < MagW; i++) begin
      if (v[i]) begin
        r = LzW'(MagW - 1 - i);
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/triangle_face_normal_top.sv
// Top level of the pipelined triangle unit face normal unit.
`timescale 1ns / 1ps
// One triangle transaction is accepted per clock while the pipeline advances, and its unit normal
// leaves through a 32-stage square root pipeline and a 16-stage divider pipeline in series;
// the whole pipeline advances whenever the output register is empty or taken.
module triangle_face_normal_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, zero pad
  input  logic [tfn_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // norm_x, norm_y, norm_z
  output logic [tfn_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // degenerate
  output logic                          m_axis_tuser_o
);

  localparam int CW = tfn_pkg::CoordW;
  localparam int EW = tfn_pkg::EdgeW;
  localparam int PW = tfn_pkg::ProdW;
  localparam int XW = tfn_pkg::CrossW;
  localparam int MW = tfn_pkg::MagW;
  localparam int ZW = tfn_pkg::LzW;
  localparam int NW = tfn_pkg::NrmW;
  localparam int QW = tfn_pkg::SqW;
  localparam int UW = tfn_pkg::SumW;
  localparam int RW = tfn_pkg::RootW;
  localparam int MR = tfn_pkg::RemW;
  localparam int DQ = tfn_pkg::QuoW;
  localparam int DN = tfn_pkg::NumW;
  localparam int DR = tfn_pkg::DrW;
  localparam int NF = tfn_pkg::NormFrac;
  localparam int OW = tfn_pkg::OutW;

  logic en;
  logic out_v_q;
  logic signed [OW-1:0] out_n_q [3];
  logic out_deg_q;

  assign en = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Stage 1: edges.
  logic v1_q;
  logic signed [EW-1:0] e1_q [3], e2_q [3];
  // Stage 2: products.
  logic v2_q;
  logic signed [PW-1:0] pa_q [3], pb_q [3];
  // Stage 3: cross product magnitude and sign.
  logic v3_q;
  logic [MW-1:0] m3_q [3];
  logic [2:0] ng3_q;
  // Stage 4: shift count.
  logic v4_q, z4_q;
  logic [MW-1:0] m4_q [3];
  logic [2:0] ng4_q;
  logic [ZW-1:0] lz4_q;
  // Stage 5: normalized magnitudes.
  logic v5_q, z5_q;
  logic [NW-1:0] m5_q [3];
  logic [2:0] ng5_q;
  // Stage 6: squares.
  logic v6_q, z6_q;
  logic [NW-1:0] m6_q [3];
  logic [2:0] ng6_q;
  logic [QW-1:0] sq6_q [3];
  // Stage 7: sum of squares.
  logic v7_q, z7_q;
  logic [NW-1:0] m7_q [3];
  logic [2:0] ng7_q;
  logic [UW-1:0] s7_q;

  logic signed [CW-1:0] p [9];
  logic signed [EW-1:0] e1_d [3], e2_d [3];
  logic signed [XW-1:0] cr [3];
  logic [MW-1:0] mx;
  logic [MW+NW-1:0] ext [3];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = s_axis_tdata_i[i*CW +: CW];
    end
    for (int c = 0; c < 3; c++) begin
      e1_d[c] = EW'(p[3+c]) - EW'(p[c]);
      e2_d[c] = EW'(p[6+c]) - EW'(p[3+c]);
      cr[c]   = XW'(pa_q[c]) - XW'(pb_q[c]);
      ext[c]  = {m4_q[c], {NW{1'b0}}} << lz4_q;
    end
    mx = m3_q[0];
    if (m3_q[1] > mx) begin
      mx = m3_q[1];
    end
    if (m3_q[2] > mx) begin
      mx = m3_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        e1_q[c] <= e1_d[c];
        e2_q[c] <= e2_d[c];
      end
      pa_q[0] <= e2_q[1] * e1_q[2];
      pb_q[0] <= e2_q[2] * e1_q[1];
      pa_q[1] <= e2_q[2] * e1_q[0];
      pb_q[1] <= e2_q[0] * e1_q[2];
      pa_q[2] <= e2_q[0] * e1_q[1];
      pb_q[2] <= e2_q[1] * e1_q[0];
      for (int c = 0; c < 3; c++) begin
        ng3_q[c] <= cr[c][XW-1];
        m3_q[c]  <= cr[c][XW-1] ? MW'(-cr[c]) : MW'(cr[c]);
      end
      m4_q  <= m3_q;
      ng4_q <= ng3_q;
      z4_q  <= (mx == '0);
      lz4_q <= tfn_pkg::lead_zeros(mx);
      for (int c = 0; c < 3; c++) begin
        m5_q[c] <= ext[c][MW+NW-1 -: NW];
      end
      ng5_q <= ng4_q;
      z5_q  <= z4_q;
      for (int c = 0; c < 3; c++) begin
        sq6_q[c] <= QW'(m5_q[c]) * QW'(m5_q[c]);
      end
      m6_q  <= m5_q;
      ng6_q <= ng5_q;
      z6_q  <= z5_q;
      s7_q  <= UW'(sq6_q[0]) + UW'(sq6_q[1]) + UW'(sq6_q[2]);
      m7_q  <= m6_q;
      ng7_q <= ng6_q;
      z7_q  <= z6_q;
    end
  end

  // Square root pipeline, one result bit per stage.
  logic          rv_q  [RW];
  logic          rz_q  [RW];
  logic [UW-1:0] rs_q  [RW];
  logic [MR-1:0] rr_q  [RW];
  logic [RW-1:0] rt_q  [RW];
  logic [NW-1:0] rm_q  [RW][3];
  logic [2:0]    rng_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic          pv, pz;
    logic [UW-1:0] ps;
    logic [MR-1:0] pr, rem_d, trial;
    logic [RW-1:0] pt, root_d;
    logic [NW-1:0] pm [3];
    logic [2:0]    png;

    always_comb begin
      if (k == 0) begin
        pv = v7_q; pz = z7_q; ps = s7_q; pr = '0; pt = '0; pm = m7_q; png = ng7_q;
      end else begin
        pv = rv_q[k-1]; pz = rz_q[k-1]; ps = rs_q[k-1]; pr = rr_q[k-1];
        pt = rt_q[k-1]; pm = rm_q[k-1]; png = rng_q[k-1];
      end
      rem_d = {pr[MR-3:0], ps[2*(RW-1-k)+1 -: 2]};
      trial = {pt, 2'b01};
      if (rem_d >= trial) begin
        rem_d  = rem_d - trial;
        root_d = {pt[RW-2:0], 1'b1};
      end else begin
        root_d = {pt[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[k] <= 1'b0;
      end else if (en) begin
        rv_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rz_q[k] <= pz; rs_q[k] <= ps; rr_q[k] <= rem_d; rt_q[k] <= root_d;
        rm_q[k] <= pm; rng_q[k] <= png;
      end
    end
  end

  // Divider set-up.
  logic          dv0_q, dz0_q;
  logic [RW-1:0] dl0_q;
  logic [DR-1:0] dr0_q [3];
  logic [DQ-1:0] dn0_q [3];
  logic [2:0]    dng0_q;
  logic [DN-1:0] num [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = {1'b0, rm_q[RW-1][c], {NF{1'b0}}} + DN'(rt_q[RW-1] >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv0_q <= 1'b0;
    end else if (en) begin
      dv0_q <= rv_q[RW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dz0_q  <= rz_q[RW-1];
      dl0_q  <= rt_q[RW-1];
      dng0_q <= rng_q[RW-1];
      for (int c = 0; c < 3; c++) begin
        dr0_q[c] <= DR'(num[c] >> DQ);
        dn0_q[c] <= num[c][DQ-1:0];
      end
    end
  end

  // Restoring divider, one quotient bit per stage for each component.
  logic          dv_q  [DQ];
  logic          dz_q  [DQ];
  logic [RW-1:0] dl_q  [DQ];
  logic [DR-1:0] dr_q  [DQ][3];
  logic [DQ-1:0] dn_q  [DQ][3];
  logic [DQ-1:0] dq_q  [DQ][3];
  logic [2:0]    dng_q [DQ];

  for (genvar k = 0; k < DQ; k++) begin : g_div
    logic          pv, pz;
    logic [RW-1:0] pl;
    logic [DR-1:0] pr [3], rem_d [3];
    logic [DQ-1:0] pn [3], pq [3], q_d [3];
    logic [2:0]    png;

    always_comb begin
      if (k == 0) begin
        pv = dv0_q; pz = dz0_q; pl = dl0_q; pr = dr0_q; pn = dn0_q; png = dng0_q;
        for (int c = 0; c < 3; c++) begin
          pq[c] = '0;
        end
      end else begin
        pv = dv_q[k-1]; pz = dz_q[k-1]; pl = dl_q[k-1]; pr = dr_q[k-1];
        pn = dn_q[k-1]; pq = dq_q[k-1]; png = dng_q[k-1];
      end
      for (int c = 0; c < 3; c++) begin
        rem_d[c] = {pr[c][DR-2:0], pn[c][DQ-1-k]};
        if (rem_d[c] >= {1'b0, pl}) begin
          rem_d[c] = rem_d[c] - {1'b0, pl};
          q_d[c]   = {pq[c][DQ-2:0], 1'b1};
        end else begin
          q_d[c]   = {pq[c][DQ-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dz_q[k] <= pz; dl_q[k] <= pl; dr_q[k] <= rem_d; dn_q[k] <= pn;
        dq_q[k] <= q_d; dng_q[k] <= png;
      end
    end
  end

  // Saturation, sign and output register.
  logic [DQ-1:0] qs [3];
  logic signed [OW-1:0] out_n_d [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qs[c] = dq_q[DQ-1][c];
      if (qs[c] > (DQ'(1) << NF)) begin
        qs[c] = DQ'(1) << NF;
      end
      if (dz_q[DQ-1]) begin
        out_n_d[c] = '0;
      end else if (dng_q[DQ-1][c]) begin
        out_n_d[c] = -OW'(qs[c]);
      end else begin
        out_n_d[c] = OW'(qs[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_q[DQ-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_n_q   <= out_n_d;
      out_deg_q <= dz_q[DQ-1];
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_deg_q;
  assign m_axis_tdata_o  = tfn_pkg::OutDataW'({out_n_q[2], out_n_q[1], out_n_q[0]});

  localparam logic signed [OW-1:0] FullPos = OW'(1) << NF;
  localparam logic signed [OW-1:0] FullNeg = -(OW'(1) << NF);

  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_deg_q) |-> (out_n_q[0] == '0 && out_n_q[1] == '0 && out_n_q[2] == '0))
    else $error("degenerate result with nonzero components");

  a_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_n_q[0] <= FullPos && out_n_q[0] >= FullNeg &&
                 out_n_q[1] <= FullPos && out_n_q[1] >= FullNeg &&
                 out_n_q[2] <= FullPos && out_n_q[2] >= FullNeg))
    else $error("normal component out of range");

  a_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_deg_q) |-> (out_n_q[0] != '0 || out_n_q[1] != '0 || out_n_q[2] != '0))
    else $error("regular result with all components zero");

endmodule

>>> sim/triangle_face_normal_top_tb.sv
// Self-checking testbench for the triangle unit face normal block with random stream stalls.
`timescale 1ns / 1ps
module triangle_face_normal_top_tb;

  typedef struct packed {
    logic [tfn_pkg::OutW-1:0] nx;
    logic [tfn_pkg::OutW-1:0] ny;
    logic [tfn_pkg::OutW-1:0] nz;
    logic                     degen;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [tfn_pkg::InDataW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [tfn_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  logic [tfn_pkg::InDataW-1:0] triangle_q[$];
  normal_t normal_q[$];
  int mismatches = 0;
  int unexpected = 0;
  int checked = 0;
  int degen_seen = 0;
  int sent = 0;
  int cyc = 0;
  bit quiet = 1'b0;
  bit hold = 1'b0;

  triangle_face_normal_top DUT (.*);

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic normal_t unit_normal(input logic [tfn_pkg::InDataW-1:0] d);
    longint p[9];
    longint e1[3];
    longint e2[3];
    longint n[3];
    logic [63:0] m[3];
    logic [63:0] mx;
    logic [63:0] s;
    logic [63:0] len;
    logic [63:0] q;
    logic [tfn_pkg::OutW-1:0] o[3];
    normal_t r;
    for (int i = 0; i < 9; i++) begin
      p[i] = longint'($signed(d[i*tfn_pkg::CoordW +: tfn_pkg::CoordW]));
    end
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[3+i] - p[i];
      e2[i] = p[6+i] - p[3+i];
    end
    n[0] = e2[1] * e1[2] - e2[2] * e1[1];
    n[1] = e2[2] * e1[0] - e2[0] * e1[2];
    n[2] = e2[0] * e1[1] - e2[1] * e1[0];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (n[i] < 0) ? -n[i] : n[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      r = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
      return r;
    end
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << tfn_pkg::NormFrac) + (len >> 1)) / len;
      if (q > (64'd1 << tfn_pkg::NormFrac)) q = 64'd1 << tfn_pkg::NormFrac;
      o[i] = (n[i] < 0) ? tfn_pkg::OutW'(-q) : tfn_pkg::OutW'(q);
    end
    r = '{nx: o[0], ny: o[1], nz: o[2], degen: 1'b0};
    return r;
  endfunction

  function automatic logic [tfn_pkg::InDataW-1:0] pack_tri(
      input logic [tfn_pkg::CoordW-1:0] c[9]);
    logic [tfn_pkg::InDataW-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*tfn_pkg::CoordW +: tfn_pkg::CoordW] = c[i];
    return d;
  endfunction

  function automatic logic [tfn_pkg::CoordW-1:0] rand_coord(input int mode);
    case (mode)
      0: return tfn_pkg::CoordW'($urandom);
      1: return tfn_pkg::CoordW'($urandom_range(0, 15) - 8);
      2: return $urandom_range(0, 1) ? tfn_pkg::CoordW'(2047) : tfn_pkg::CoordW'(-2048);
      default: return tfn_pkg::CoordW'($urandom_range(0, 255) - 128);
    endcase
  endfunction

  initial begin
    logic [tfn_pkg::CoordW-1:0] c[9];
    int mode;
    foreach (c[i]) c[i] = '0;
    triangle_q.push_back(pack_tri(c));
    foreach (c[i]) c[i] = tfn_pkg::CoordW'(2047);
    triangle_q.push_back(pack_tri(c));
    foreach (c[i]) c[i] = tfn_pkg::CoordW'(-2048);
    triangle_q.push_back(pack_tri(c));
    c = '{tfn_pkg::CoordW'(-2048), tfn_pkg::CoordW'(-2048), tfn_pkg::CoordW'(-2048),
          tfn_pkg::CoordW'(2047), tfn_pkg::CoordW'(-2048), tfn_pkg::CoordW'(-2048),
          tfn_pkg::CoordW'(2047), tfn_pkg::CoordW'(2047), tfn_pkg::CoordW'(-2048)};
    triangle_q.push_back(pack_tri(c));
    c = '{tfn_pkg::CoordW'(-2048), tfn_pkg::CoordW'(2047), tfn_pkg::CoordW'(-2048),
          tfn_pkg::CoordW'(2047), tfn_pkg::CoordW'(-2048), tfn_pkg::CoordW'(2047),
          tfn_pkg::CoordW'(-2048), tfn_pkg::CoordW'(-2048), tfn_pkg::CoordW'(2047)};
    triangle_q.push_back(pack_tri(c));
    // Unit triangles in each axis plane, a collinear triple, a long thin triangle and a diagonal normal.
    c = '{0, 0, 0, 1, 0, 0, 1, 1, 0};
    triangle_q.push_back(pack_tri(c));
    c = '{0, 0, 0, 0, 1, 0, 0, 1, 1};
    triangle_q.push_back(pack_tri(c));
    c = '{0, 0, 0, 0, 0, 1, 1, 0, 1};
    triangle_q.push_back(pack_tri(c));
    c = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
    triangle_q.push_back(pack_tri(c));
    c = '{0, 0, 0, 2047, 0, 0, 2047, 1, 0};
    triangle_q.push_back(pack_tri(c));
    c = '{0, 0, 0, 1, 1, 0, 2, 2, 1};
    triangle_q.push_back(pack_tri(c));
    for (int k = 0; k < 540; k++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) c[i] = rand_coord(mode);
      if ($urandom_range(0, 19) == 0) c[6:8] = c[3:5];
      triangle_q.push_back(pack_tri(c));
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    quiet <= (cyc % 4000) < 600;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o && sent + 1 == 300) begin
        hold <= 1'b1;
      end else if (hold && normal_q.size() == 0) begin
        hold <= 1'b0;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (s_axis_tvalid_i) begin
          normal_q.push_back(unit_normal(s_axis_tdata_i));
          sent <= sent + 1;
        end
        if (triangle_q.size() != 0 && !(hold || (s_axis_tvalid_i && sent + 1 == 300))
            && (quiet || $urandom_range(0, 99) >= 18)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= triangle_q.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= quiet || $urandom_range(0, 99) >= 18;
    end
  end

  always @(posedge clk_i) begin
    normal_t exp_n;
    normal_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{nx: m_axis_tdata_o[0 +: tfn_pkg::OutW],
              ny: m_axis_tdata_o[tfn_pkg::OutW +: tfn_pkg::OutW],
              nz: m_axis_tdata_o[2*tfn_pkg::OutW +: tfn_pkg::OutW], degen: m_axis_tuser_o};
      if (normal_q.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transaction: %p", got);
      end else begin
        exp_n = normal_q.pop_front();
        checked++;
        if (got.degen) degen_seen++;
        if (got !== exp_n) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", exp_n, got);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (triangle_q.size() == 0 && !s_axis_tvalid_i && normal_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("Checked %0d normals, %0d degenerate, with random stalls on both sides.",
             checked, degen_seen);
    if (mismatches == 0 && normal_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d normals outstanding.", normal_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
hdl/tfn_pkg.sv
hdl/triangle_face_normal_top.sv
sim/triangle_face_normal_top_tb.sv
